@@ hdl/pdt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdt_pkg
// Types, constants and a helper function shared by the duplicate table.
// ----------------------------------------------------------------------------
package pdt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int ID_W   = 48;
  localparam int SEQ_W  = 32;
  localparam int TYPE_W = 8;
  localparam int TIME_W = 48;

  localparam logic [TIME_W-1:0] TTL_RESET = TIME_W'(30000);

  localparam logic [TYPE_W-1:0] TYPE_CODE_A = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] TYPE_CODE_B = TYPE_W'(2);
  localparam logic [TYPE_W-1:0] TYPE_CODE_C = TYPE_W'(3);

  localparam logic [TYPE_W-1:0] TYPE_BIT_A     = TYPE_W'(1) << 0;
  localparam logic [TYPE_W-1:0] TYPE_BIT_B     = TYPE_W'(1) << 1;
  localparam logic [TYPE_W-1:0] TYPE_BIT_C     = TYPE_W'(1) << 2;
  localparam logic [TYPE_W-1:0] TYPE_BIT_OTHER = TYPE_W'(1) << 7;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   source_id;
    logic [SEQ_W-1:0]  seq_number;
    logic [TYPE_W-1:0] type_mask;
    logic [TIME_W-1:0] now_time;
  } item_t;

  typedef struct packed {
    logic walk;
    idx_t pos;
    logic insert;
    idx_t slot;
  } ctrl_t;

  typedef struct packed {
    logic              hit;
    logic              dup;
    logic              free_found;
    idx_t              vacant_idx;
    idx_t              min_idx;
    logic [TIME_W-1:0] min_time;
  } carry_t;

  localparam carry_t CARRY_INIT = '{
    hit:        1'b0,
    dup:        1'b0,
    free_found: 1'b0,
    vacant_idx: '0,
    min_idx:    '0,
    min_time:   '1
  };

  function automatic logic [TYPE_W-1:0] type_bit(input logic [TYPE_W-1:0] code);
    logic [TYPE_W-1:0] mask;
    case (code)
      TYPE_CODE_A: mask = TYPE_BIT_A;
      TYPE_CODE_B: mask = TYPE_BIT_B;
      TYPE_CODE_C: mask = TYPE_BIT_C;
      default:     mask = TYPE_BIT_OTHER;
    endcase
    return mask;
  endfunction

endpackage

@@ hdl/pdt_if.sv @@
// ----------------------------------------------------------------------------
// pdt_if
// Valid/ready channels for lookup requests and duplicate responses.
// ----------------------------------------------------------------------------
interface pdt_req_if;
  logic                      valid;
  logic                      ready;
  logic [pdt_pkg::ID_W-1:0]   source_id;
  logic [pdt_pkg::SEQ_W-1:0]  seq_number;
  logic [pdt_pkg::TYPE_W-1:0] msg_type;
  logic [pdt_pkg::TIME_W-1:0] now_time;

  modport source (output valid, source_id, seq_number, msg_type, now_time, input ready);
  modport sink   (input valid, source_id, seq_number, msg_type, now_time, output ready);
endinterface

interface pdt_resp_if;
  logic valid;
  logic ready;
  logic is_duplicate;

  modport source (output valid, is_duplicate, input ready);
  modport sink   (input valid, is_duplicate, output ready);
endinterface

@@ hdl/pdt_cell.sv @@
// ----------------------------------------------------------------------------
// pdt_cell
// One table entry with its expiry, match, free-slot and oldest-entry logic.
// ----------------------------------------------------------------------------
module pdt_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  pdt_pkg::idx_t              cell_idx,
  input  pdt_pkg::ctrl_t             ctrl,
  input  pdt_pkg::item_t             item,
  input  logic [pdt_pkg::TIME_W-1:0] ttl,
  input  pdt_pkg::carry_t            carry_in,
  output pdt_pkg::carry_t            carry_out
);
  import pdt_pkg::*;

  logic              valid;
  logic [ID_W-1:0]   source;
  logic [SEQ_W-1:0]  seq;
  logic [TIME_W-1:0] stamp;
  logic [TYPE_W-1:0] types;
  carry_t            carry_next;

  logic              active;
  logic              insert;
  logic [TIME_W-1:0] age;
  logic              expired;
  logic              live;
  logic              match;
  logic              seen;

  assign active  = ctrl.walk && (ctrl.pos == cell_idx);
  assign insert  = ctrl.insert && (ctrl.slot == cell_idx);
  assign age     = item.now_time - stamp;
  assign expired = valid && (item.now_time > stamp) && (age > ttl);
  assign live    = valid && !expired;
  assign match   = live && !carry_in.hit && (source == item.source_id) &&
                   (seq == item.seq_number);
  assign seen    = |(types & item.type_mask);

  always_comb begin
    carry_next = carry_in;
    if (match) begin
      carry_next.hit = 1'b1;
      carry_next.dup = seen;
    end
    if (!live && !carry_in.free_found) begin
      carry_next.free_found = 1'b1;
      carry_next.vacant_idx = cell_idx;
    end
    if (live && (stamp < carry_in.min_time)) begin
      carry_next.min_time = stamp;
      carry_next.min_idx  = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (active && expired) begin
      valid <= 1'b0;
    end else if (insert) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      carry_out <= carry_next;
      if (match) begin
        stamp <= item.now_time;
        types <= types | item.type_mask;
      end
    end
    if (insert) begin
      source <= item.source_id;
      seq    <= item.seq_number;
      stamp  <= item.now_time;
      types  <= item.type_mask;
    end
  end

endmodule

@@ hdl/packet_dedup_table_unit.sv @@
// ----------------------------------------------------------------------------
// packet_dedup_table_unit
// Duplicate suppression table with time-to-live over a row of entry cells.
// ----------------------------------------------------------------------------
// One request is handled at a time: the request is latched, then a search
// token walks the row of cells one cell per cycle, expiring, matching and
// ranking entries, and a final write step stores the new entry when no
// match was found and loads the response register. A response waiting in
// that register does not stop the next request from being taken, but the
// write step of that request waits until the earlier response has been
// transferred. The user must write the time-to-live through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce it.
module packet_dedup_table_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [pdt_pkg::TIME_W-1:0] cfg_wr_data,
  pdt_req_if.sink                    request,
  pdt_resp_if.source                 response
);
  import pdt_pkg::*;

  localparam idx_t LAST_POS = IDX_W'(TABLE_ENTRIES - 1);

  state_t            state;
  state_t            state_next;
  idx_t              pos;
  item_t             item;
  logic [TIME_W-1:0] ttl;
  logic              resp_valid;
  logic              resp_dup;

  logic   take;
  logic   finish;
  ctrl_t  ctrl;
  carry_t chain [TABLE_ENTRIES];
  carry_t result;

  assign result = chain[TABLE_ENTRIES-1];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (take) state_next = ST_WALK;
      ST_WALK:  if (pos == LAST_POS) state_next = ST_WRITE;
      ST_WRITE: if (finish) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    request.ready = 1'b0;
    finish        = 1'b0;
    ctrl.walk     = 1'b0;
    ctrl.pos      = pos;
    ctrl.insert   = 1'b0;
    ctrl.slot     = result.free_found ? result.vacant_idx : result.min_idx;
    case (state)
      ST_IDLE:  request.ready = 1'b1;
      ST_WALK:  ctrl.walk = 1'b1;
      ST_WRITE: begin
        finish      = !resp_valid || response.ready;
        ctrl.insert = finish && !result.hit;
      end
      default: ;
    endcase
  end

  assign take = request.valid && request.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      ttl        <= TTL_RESET;
      resp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        ttl <= cfg_wr_data;
      end
      if (take) begin
        pos <= '0;
      end else if (ctrl.walk) begin
        pos <= pos + IDX_W'(1);
      end
      if (finish) begin
        resp_valid <= 1'b1;
      end else if (response.ready) begin
        resp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.source_id  <= request.source_id;
      item.seq_number <= request.seq_number;
      item.type_mask  <= type_bit(request.msg_type);
      item.now_time   <= request.now_time;
    end
    if (finish) begin
      resp_dup <= result.hit && result.dup;
    end
  end

  assign response.valid        = resp_valid;
  assign response.is_duplicate = resp_dup;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    pdt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_idx  (IDX_W'(k)),
      .ctrl      (ctrl),
      .item      (item),
      .ttl       (ttl),
      .carry_in  ((k == 0) ? CARRY_INIT : chain[(k == 0) ? 0 : k - 1]),
      .carry_out (chain[k])
    );
  end

endmodule

@@ hdl/pdt_checker.sv @@
// ----------------------------------------------------------------------------
// pdt_checker
// Port-level checks on request and response ordering of the duplicate table.
// ----------------------------------------------------------------------------
module pdt_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic resp_valid,
  input logic resp_ready,
  input logic resp_dup
);

  logic [1:0] pending;
  logic [1:0] pending_next;
  logic       req_xfer;
  logic       resp_xfer;

  assign req_xfer  = req_valid && req_ready;
  assign resp_xfer = resp_valid && resp_ready;

  always_comb begin
    pending_next = pending;
    if (req_xfer && !resp_xfer) begin
      pending_next = pending + 2'd1;
    end else if (resp_xfer && !req_xfer) begin
      pending_next = pending - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending_next;
    end
  end

  a_resp_held: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid)
    else $error("Response withdrawn before its transfer.");

  a_resp_stable: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> $stable(resp_dup))
    else $error("Stalled response changed its payload.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> !req_ready)
    else $error("Request taken while another was in progress.");

  a_resp_has_req: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> pending != 2'd0)
    else $error("Response shown without an outstanding request.");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("More than two requests outstanding.");

endmodule

bind packet_dedup_table_unit pdt_checker u_pdt_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (request.valid),
  .req_ready  (request.ready),
  .resp_valid (response.valid),
  .resp_ready (response.ready),
  .resp_dup   (response.is_duplicate)
);
